@@ src/ffisa_pkg.sv @@
// Package for the first-fit interval server assignment block.
// Holds the shared constants, state encoding and controller/datapath structs.
// Depends on nothing.
`default_nettype none

package ffisa_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int TIME_W      = 32;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int IN_DATA_W   = 2 * TIME_W;
  localparam int OUT_DATA_W  = 16;
  localparam int OUT_USER_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SERVERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic place;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ src/ffisa_ctrl.sv @@
// Controller state machine for the first-fit server assignment block.
// Sequences load, scan, place and output push; depends on ffisa_pkg.
`default_nettype none

module ffisa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire ffisa_pkg::ctrl_sts_t sts,
  output ffisa_pkg::ctrl_cmd_t      cmd
);
  import ffisa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit || sts.exhausted) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.place = sts.hit || sts.exhausted;
      end
      ST_DONE: begin
        cmd.push = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/ffisa_dp.sv @@
// Datapath for the first-fit server assignment block: task registers, the
// free-time memory, scan pointer, compare stage and output register.
// Depends on ffisa_pkg.
`default_nettype none

module ffisa_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [ffisa_pkg::IN_DATA_W-1:0]     s_tdata,
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [ffisa_pkg::OUT_DATA_W-1:0]         m_tdata,
  output logic [ffisa_pkg::OUT_USER_W-1:0]         m_tuser,
  input  wire ffisa_pkg::ctrl_cmd_t                cmd,
  output ffisa_pkg::ctrl_sts_t                     sts
);
  import ffisa_pkg::*;

  logic [TIME_W-1:0] free_mem [MAX_SERVERS];
  logic [TIME_W-1:0] rd_data;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] end_r;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_ptr;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  res_idx;
  logic [CNT_W-1:0]  res_cnt;
  logic              res_open;
  logic              res_ovf;

  logic              issue;
  logic              fits;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  assign issue = rd_ptr < count;
  assign fits  = rd_data <= start_r;

  assign sts.hit       = cmp_valid && fits;
  assign sts.exhausted = !cmp_valid && !issue;
  assign sts.out_free  = !m_tvalid || m_tready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    if (cmd.place) begin
      if (cmp_valid && fits) begin
        wr_en   = 1'b1;
        wr_addr = cmp_idx;
      end else if (count < CNT_MAX) begin
        wr_en   = 1'b1;
        wr_addr = count[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= free_mem[rd_ptr[IDX_W-1:0]];
    if (wr_en) begin
      free_mem[wr_addr] <= end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= s_tdata[TIME_W-1:0];
      end_r   <= s_tdata[IN_DATA_W-1:TIME_W];
    end
    if (cmd.place) begin
      if (cmp_valid && fits) begin
        res_idx  <= cmp_idx;
        res_cnt  <= count;
        res_open <= 1'b0;
        res_ovf  <= 1'b0;
      end else if (count < CNT_MAX) begin
        res_idx  <= count[IDX_W-1:0];
        res_cnt  <= count + CNT_W'(1);
        res_open <= 1'b1;
        res_ovf  <= 1'b0;
      end else begin
        res_idx  <= '0;
        res_cnt  <= count;
        res_open <= 1'b0;
        res_ovf  <= 1'b1;
      end
    end
    if (cmd.push) begin
      m_tdata <= {(OUT_DATA_W - CNT_W - IDX_W)'(0), res_cnt, res_idx};
      m_tuser <= {res_ovf, res_open};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
      cmp_idx   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (s_tuser) count <= '0;
        rd_ptr    <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        if (issue) rd_ptr <= rd_ptr + CNT_W'(1);
        cmp_valid <= issue;
        cmp_idx   <= rd_ptr[IDX_W-1:0];
      end
      if (cmd.place && !(cmp_valid && fits) && (count < CNT_MAX)) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/first_fit_interval_server_assign_core.sv @@
// Top level of the first-fit interval server assignment block.
// An item is loaded, then the open servers are scanned in index order until the first fit or the end, then placed.
// No new item is taken until the last result is pushed to the output register; the scan length sets the rate.
// The scan reads one free-time entry per cycle from a memory with one read port and one write port.
// Reset clears the server count and output valid; free-time entries are never read unwritten.
// Depends on ffisa_pkg, ffisa_ctrl and ffisa_dp.
`default_nettype none

module first_fit_interval_server_assign_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // Fields from bit 0: task_start[31:0], task_end[63:32].
  input  wire logic [ffisa_pkg::IN_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: new_set.
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // Fields from bit 0: server_index[3:0], servers_in_use[8:4], zero fill.
  output logic [ffisa_pkg::OUT_DATA_W-1:0]         m_tdata,
  // Fields from bit 0: opened_new, overflow.
  output logic [ffisa_pkg::OUT_USER_W-1:0]         m_tuser
);
  import ffisa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ffisa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffisa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

@@ src/ffisa_checker.sv @@
// Port-level checker for the first-fit server assignment block, with its bind.
// Depends on ffisa_pkg and the top level's ports.
`default_nettype none

module ffisa_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [ffisa_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic [ffisa_pkg::OUT_USER_W-1:0]    m_tuser
);
  import ffisa_pkg::*;

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata[8:4] == CNT_MAX) && (m_tdata[3:0] == '0))
    else $error("Overflow item without a saturated count and zero index.");

  a_open_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("Item marks both a new server and an overflow.");

  a_open_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (CNT_W'(m_tdata[3:0]) + CNT_W'(1)) == m_tdata[8:4])
    else $error("New server index does not match the count in use.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result item changed.");

endmodule

bind first_fit_interval_server_assign_core ffisa_checker u_ffisa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
